FILE: src/edd_pkg.sv
// Shared definitions for the error diffusion dither core.
// Defaults, register indexes, diffusion weights and the lane control struct.
// No dependencies.
`timescale 1ns / 1ps

package edd_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int ERROR_BITS_DEF = 11;

	localparam int NUM_CH     = 3;
	localparam int SAMPLE_W   = 8;
	localparam int IMG_W_W    = 12;
	localparam int IMG_H_W    = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DATA_W = 8;

	localparam logic [IMG_W_W-1:0] IMG_W_RESET = 12'd640;
	localparam logic [IMG_H_W-1:0] IMG_H_RESET = 16'd480;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

	// quantizer threshold and the level a set bit stands for
	localparam int THRESHOLD = 127;
	localparam int FULL_LEVEL = 255;

	// diffusion weights in sixteenths
	localparam logic [3:0] K_RIGHT       = 4'd7;
	localparam logic [3:0] K_BELOW_LEFT  = 4'd3;
	localparam logic [3:0] K_BELOW       = 4'd5;
	localparam logic [3:0] K_BELOW_RIGHT = 4'd1;
	localparam int         K_SHIFT       = 4;

	typedef struct packed {
		logic adv;        // pixel in stage 1 moves to the output register
		logic first_row;  // line memory contents do not apply
		logic last_row;   // nothing diffuses downward
		logic last_col;   // nothing diffuses to the right
		logic col_zero;   // flush the held last-column error instead of a left term
	} edd_ctl_t;

endpackage

FILE: src/edd_line_mem.sv
// Line memory holding the downward errors of all three channels per column.
// One write port, one registered read port with write-through on a same-address hit.
// Uses edd_pkg for the default parameter values; sized by parameters.
`timescale 1ns / 1ps

module edd_line_mem
	import edd_pkg::*;
#(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int DW    = NUM_CH * ERROR_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			// forward the word being written so the read sees the new value
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/edd_lane.sv
// One color channel of the dither: quantizer, error split and the carried errors.
// Holds the right carry, the diagonal term and the pending below-left sum.
// Depends on edd_pkg.
`timescale 1ns / 1ps

module edd_lane
	import edd_pkg::*;
#(
	parameter int EB = ERROR_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  edd_ctl_t            ctl,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [EB-1:0]       below,
	output logic                bit_on,
	output logic [EB-1:0]       wdata
);

	localparam int XW = EB + 5;
	localparam int HI = (1 << (EB - 1)) - 1;
	localparam int LO = -HI - 1;
	localparam logic signed [XW-1:0] SAT_HI = XW'(HI);
	localparam logic signed [XW-1:0] SAT_LO = XW'(LO);
	localparam logic signed [EB-1:0] THR    = EB'(THRESHOLD);

	function automatic logic signed [EB-1:0] sat(input logic signed [XW-1:0] x);
		logic signed [EB-1:0] r;
		if (x > SAT_HI) begin
			r = SAT_HI[EB-1:0];
		end else if (x < SAT_LO) begin
			r = SAT_LO[EB-1:0];
		end else begin
			r = x[EB-1:0];
		end
		return r;
	endfunction

	// e * k / 16, truncated toward zero
	function automatic logic signed [XW-1:0] share(input logic signed [EB+1:0] e,
	                                               input logic [3:0] k);
		logic signed [EB+5:0] ex;
		logic signed [EB+5:0] kx;
		logic signed [EB+5:0] p;
		logic signed [EB+5:0] s;
		ex = {{4{e[EB+1]}}, e};
		kx = {{(EB+2){1'b0}}, k};
		p  = ex * kx;
		if (p[EB+5]) begin
			p = p + (EB+6)'(15);
		end
		s = p >>> K_SHIFT;
		return s[XW-1:0];
	endfunction

	function automatic logic signed [XW-1:0] ext(input logic signed [EB-1:0] x);
		return {{5{x[EB-1]}}, x};
	endfunction

	logic signed [EB-1:0] rc_q;
	logic signed [EB-1:0] diag_q;
	logic signed [EB-1:0] pend_q;

	logic signed [EB-1:0] below_m;
	logic signed [XW-1:0] v_sum;
	logic signed [EB-1:0] v;
	logic signed [EB+1:0] e;
	logic signed [XW-1:0] sh7, sh3, sh5, sh1;
	logic signed [XW-1:0] left_sum, mid_sum;

	always_comb begin
		below_m  = ctl.first_row ? '0 : below;
		v_sum    = $signed({{(XW-SAMPLE_W){1'b0}}, sample}) + ext(rc_q) + ext(below_m);
		v        = sat(v_sum);
		bit_on   = (v >= THR);
		e        = {{2{v[EB-1]}}, v} - (bit_on ? (EB+2)'(FULL_LEVEL) : '0);
		sh7      = share(e, K_RIGHT);
		sh3      = share(e, K_BELOW_LEFT);
		sh5      = share(e, K_BELOW);
		sh1      = share(e, K_BELOW_RIGHT);
		left_sum = ext(pend_q) + sh3;
		mid_sum  = ext(diag_q) + sh5;
		// at column zero the pending word is the previous row's last column
		wdata    = ctl.col_zero ? pend_q : sat(left_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q   <= '0;
			diag_q <= '0;
			pend_q <= '0;
		end else if (ctl.adv) begin
			rc_q   <= ctl.last_col ? '0 : sat(sh7);
			diag_q <= (ctl.last_col || ctl.last_row) ? '0 : sh1[EB-1:0];
			pend_q <= sat(mid_sum);
		end
	end

endmodule

FILE: src/error_diffusion_dither_rgb_core.sv
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tdata: red, green, blue samples
// m_*       out  m_tvalid/m_tready    m_tdata: red, green, blue bits; m_tlast: frame end
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel per clock sustained while the output is not stalled.
// The rate is set by the per-channel error feedback (right carry) closing through its register
// and by the line memory's single read and single write port.
// Reset clears counters, carries and valid flags; the line memory needs no clearing pass.
// A stalled output holds stage 1 and the memory read data; an empty stage 1 takes one more pixel.
`timescale 1ns / 1ps

module error_diffusion_dither_rgb_core
	import edd_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int ERROR_BITS = ERROR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // red_on[0], green_on[1], blue_on[2], zeros
	output logic                  m_tlast,   // frame_end
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int XW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
	localparam int EB = ERROR_BITS;
	localparam int MW = NUM_CH * EB;

	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMG_W_RESET;
			height_q <= IMG_H_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// position of the next pixel
	logic [XW-1:0]      w_ext;
	logic [CW-1:0]      col_last;
	logic [IMG_H_W-1:0] row_last;
	logic [CW-1:0]      col_q;
	logic [IMG_H_W-1:0] row_q;
	logic [CW-1:0]      col_cur;
	logic               last_col, last_row, first_row;

	always_comb begin
		w_ext = XW'(width_q);
		if (w_ext < XW'(2)) begin
			col_last = CW'(1);
		end else if (w_ext > XW'(MAX_WIDTH)) begin
			col_last = CW'(MAX_WIDTH - 1);
		end else begin
			col_last = CW'(w_ext - XW'(1));
		end
		row_last  = (height_q == '0) ? '0 : height_q - IMG_H_W'(1);
		last_col  = (col_q >= col_last);
		col_cur   = last_col ? col_last : col_q;
		first_row = (row_q == '0);
		last_row  = (row_q >= row_last);
	end

	logic in_fire;
	logic adv;
	logic valid_s1;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + IMG_H_W'(1);
			end else begin
				col_q <= col_cur + CW'(1);
			end
		end
	end

	// stage 1: pixel and its position, aligned with the line memory read
	logic [23:0]   pix_s1;
	logic [CW-1:0] col_s1;
	logic          first_row_s1, last_row_s1, last_col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1       <= s_tdata;
			col_s1       <= col_cur;
			first_row_s1 <= first_row;
			last_row_s1  <= last_row;
			last_col_s1  <= last_col;
		end
	end

	// the last column's word is written at the next row's first pixel
	logic          defer_q;
	logic [CW-1:0] defer_addr_q;
	logic          col_zero_s1;
	logic          mem_we;
	logic [CW-1:0] mem_waddr;
	logic [MW-1:0] mem_wdata;
	logic [MW-1:0] mem_rdata;

	assign col_zero_s1 = (col_s1 == '0);
	assign mem_we      = adv && (col_zero_s1 ? defer_q : !last_row_s1);
	assign mem_waddr   = col_zero_s1 ? defer_addr_q : col_s1 - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			defer_q      <= 1'b0;
			defer_addr_q <= '0;
		end else if (adv) begin
			defer_q      <= last_col_s1 && !last_row_s1;
			defer_addr_q <= col_s1;
		end
	end

	edd_line_mem #(
		.DEPTH (MAX_WIDTH),
		.DW    (MW)
	) u_mem (
		.clk   (clk),
		.re    (in_fire),
		.raddr (col_cur),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	edd_ctl_t      ctl;
	logic [NUM_CH-1:0] bits;

	always_comb begin
		ctl.adv       = adv;
		ctl.first_row = first_row_s1;
		ctl.last_row  = last_row_s1;
		ctl.last_col  = last_col_s1;
		ctl.col_zero  = col_zero_s1;
	end

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
		edd_lane #(
			.EB (EB)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sample (pix_s1[ch*SAMPLE_W +: SAMPLE_W]),
			.below  (mem_rdata[ch*EB +: EB]),
			.bit_on (bits[ch]),
			.wdata  (mem_wdata[ch*EB +: EB])
		);
	end

	// output register: merge the lane bits with the frame marker
	logic [NUM_CH-1:0] bits_q;
	logic              last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bits_q <= bits;
			last_q <= last_col_s1 && last_row_s1;
		end
	end

	assign m_tdata = {{(OUT_DATA_W-NUM_CH){1'b0}}, bits_q};
	assign m_tlast = last_q;

endmodule

FILE: src/edd_checker.sv
// Port-level checks for the error diffusion dither core, bound to the top level.
// Tracks items in flight from the two stream handshakes. Depends on edd_pkg.
`timescale 1ns / 1ps

module edd_checker
	import edd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);

	logic [2:0] inflight_q;
	logic       in_fire, out_fire;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_fire && !out_fire) begin
			inflight_q <= inflight_q + 3'd1;
		end else if (out_fire && !in_fire) begin
			inflight_q <= inflight_q - 3'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed or dropped while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd0 |-> !m_tvalid)
		else $error("output item without an accepted input item");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd2)
		else $error("more than two items held inside the core");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd2 && !m_tready |-> !s_tready)
		else $error("input taken while both stages are full and stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:NUM_CH] == '0)
		else $error("unused output bits not zero");

endmodule

bind error_diffusion_dither_rgb_core edd_checker u_edd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
